### sv/cmf_pkg.sv
// shared types, constants and helpers of the five-point cross mean filter
`default_nettype none

package cmf_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int DIM_W  = 12;
    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int PEND_W = DIM_W + 1;
    localparam int MAX_CR = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W  = ((MAX_CR > PEND_W) ? MAX_CR : PEND_W) + 1;

    // floor(sum / 5) as (sum * 13108) >> 16, exact for sums of five 8-bit values
    localparam int SUM_W      = CH_W + 3;
    localparam int MEAN_RECIP = 13108;
    localparam int MEAN_SHIFT = 16;
    localparam int PROD_W     = SUM_W + 14;

    localparam int TAPS = 5;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic            req_type;
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            frame_end;
    } t_out_item;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        t_pix             data;
    } t_ls_wr;

    // zero acts as one, anything above the store limit acts as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned lim);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (CMP_W'(v) > CMP_W'(lim)) begin
            return DIM_W'(lim);
        end else begin
            return v;
        end
    endfunction

endpackage

`default_nettype wire

### sv/cmf_line_store.sv
// one row store: single write port, registered read with same-cycle write bypass
`default_nettype none

module cmf_line_store (
    input  wire                        i_clk,
    input  cmf_pkg::t_ls_wr            i_wr,
    input  wire                        i_rd_en,
    input  wire  [cmf_pkg::COL_W-1:0]  i_rd_addr,
    output cmf_pkg::t_pix              o_rd_data
);

    cmf_pkg::t_pix mem [cmf_pkg::MAX_WIDTH];

    cmf_pkg::t_pix r_rd_mem;
    cmf_pkg::t_pix r_byp;
    logic          r_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_mem <= mem[i_rd_addr];
            r_byp    <= i_wr.data;
            r_hit    <= i_wr.en && (i_wr.addr == i_rd_addr);
        end
    end

    // a read that meets a write to the same column sees the new data
    assign o_rd_data = r_hit ? r_byp : r_rd_mem;

endmodule

`default_nettype wire

### sv/cmf_mean5.sv
// per-channel truncated mean of five rgb pixels
`default_nettype none

module cmf_mean5 (
    input  cmf_pkg::t_pix i_pix [cmf_pkg::TAPS],
    output cmf_pkg::t_pix o_mean
);

    always_comb begin : mean_calc
        logic [cmf_pkg::SUM_W-1:0]  sum;
        logic [cmf_pkg::PROD_W-1:0] prod;
        o_mean = '0;
        for (int c = 0; c < 3; c++) begin
            sum = '0;
            for (int k = 0; k < cmf_pkg::TAPS; k++) begin
                sum = sum + cmf_pkg::SUM_W'(i_pix[k][c*cmf_pkg::CH_W +: cmf_pkg::CH_W]);
            end
            prod = cmf_pkg::PROD_W'(sum) * cmf_pkg::PROD_W'(cmf_pkg::MEAN_RECIP);
            o_mean[c*cmf_pkg::CH_W +: cmf_pkg::CH_W] =
                prod[cmf_pkg::MEAN_SHIFT +: cmf_pkg::CH_W];
        end
    end

endmodule

`default_nettype wire

### sv/cross_mean_filter_top.sv
// Five-point cross mean filter over a raster-order RGB stream. Every pixel
// transaction comes out as one filtered pixel, image_width + 1 pixel
// transactions later; border pixels are zero and the last pixel of a frame
// carries frame_end. Drain transactions after a frame push out the results
// still owed; a drain with nothing owed gives nothing. The block takes one
// transaction per clock: the input is registered together with the reads of
// the two row stores (one read and one write port each), and the mean and
// border logic feeds the output register. The input stalls only while a
// result is due and the output register is full and stalled. There is no
// clearing pass after reset. Write image_width and image_height only while
// the block is idle.
`default_nettype none

module cross_mean_filter_top (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [cmf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [cmf_pkg::DIM_W-1:0]      i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  cmf_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output cmf_pkg::t_out_item             o_out_item
);

    localparam int CMP_W = cmf_pkg::CMP_W;

    // configuration
    logic [cmf_pkg::DIM_W-1:0] r_width;
    logic [cmf_pkg::DIM_W-1:0] r_height;
    logic [cmf_pkg::DIM_W-1:0] w_dim;
    logic [cmf_pkg::DIM_W-1:0] h_dim;

    // input position
    logic [cmf_pkg::COL_W-1:0] r_in_col;
    logic [cmf_pkg::ROW_W-1:0] r_in_row;
    logic                      in_accept;
    logic                      in_is_px;
    logic                      in_col_wrap;
    logic                      in_row_wrap;

    // registered transaction
    logic                      r_s2_valid;
    cmf_pkg::t_in_item         r_s2_item;
    logic [cmf_pkg::COL_W-1:0] r_s2_col;
    logic                      r_s2_last;
    logic                      s2_px;
    logic                      s2_has_res;
    logic                      s2_move;
    logic                      s2_fire;
    cmf_pkg::t_pix             s2_pix;
    cmf_pkg::t_pix             up_rd;
    cmf_pkg::t_pix             mid_rd;

    // filter state
    cmf_pkg::t_pix             r_win [cmf_pkg::TAPS];
    cmf_pkg::t_pix             n_win [cmf_pkg::TAPS];
    logic [cmf_pkg::PEND_W-1:0] r_pend;
    logic [cmf_pkg::PEND_W-1:0] n_pend;
    logic                      r_primed;
    logic                      n_primed;
    logic [cmf_pkg::COL_W-1:0] r_out_col;
    logic [cmf_pkg::COL_W-1:0] n_out_col;
    logic [cmf_pkg::ROW_W-1:0] r_out_row;
    logic [cmf_pkg::ROW_W-1:0] n_out_row;
    logic                      out_last;
    logic                      interior;

    cmf_pkg::t_pix             taps [cmf_pkg::TAPS];
    cmf_pkg::t_pix             mean;
    cmf_pkg::t_ls_wr           wr_upper;
    cmf_pkg::t_ls_wr           wr_middle;

    logic                      r_out_valid;
    cmf_pkg::t_out_item        r_out_item;
    cmf_pkg::t_out_item        res_item;

    assign w_dim = cmf_pkg::clamp_dim(r_width, cmf_pkg::MAX_WIDTH);
    assign h_dim = cmf_pkg::clamp_dim(r_height, cmf_pkg::MAX_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= cmf_pkg::WIDTH_RESET;
            r_height <= cmf_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cmf_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                cmf_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- input side: column address and frame position ----
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_is_px    = i_in_item.req_type == cmf_pkg::REQ_PIXEL;
    assign in_col_wrap = CMP_W'(r_in_col) + CMP_W'(1) >= CMP_W'(w_dim);
    assign in_row_wrap = CMP_W'(r_in_row) + CMP_W'(1) >= CMP_W'(h_dim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else if (in_accept && in_is_px) begin
            if (in_col_wrap) begin
                r_in_col <= '0;
                r_in_row <= in_row_wrap ? '0 : r_in_row + cmf_pkg::ROW_W'(1);
            end else begin
                r_in_col <= r_in_col + cmf_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_move) begin
            r_s2_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_s2_item <= i_in_item;
            r_s2_col  <= r_in_col;
            r_s2_last <= in_col_wrap && in_row_wrap;
        end
    end

    // ---- row stores ----
    assign s2_px  = r_s2_item.req_type == cmf_pkg::REQ_PIXEL;
    assign s2_pix = {r_s2_item.red_in, r_s2_item.green_in, r_s2_item.blue_in};

    assign wr_upper  = '{en: s2_fire && s2_px, addr: r_s2_col, data: mid_rd};
    assign wr_middle = '{en: s2_fire && s2_px, addr: r_s2_col, data: s2_pix};

    cmf_line_store u_upper (
        .i_clk     (i_clk),
        .i_wr      (wr_upper),
        .i_rd_en   (in_accept && in_is_px),
        .i_rd_addr (r_in_col),
        .o_rd_data (up_rd)
    );

    cmf_line_store u_middle (
        .i_clk     (i_clk),
        .i_wr      (wr_middle),
        .i_rd_en   (in_accept && in_is_px),
        .i_rd_addr (r_in_col),
        .o_rd_data (mid_rd)
    );

    // ---- result stage ----
    assign s2_has_res = s2_px ? (CMP_W'(r_pend) > CMP_W'(w_dim))
                              : (r_primed && (r_pend != '0));
    assign s2_move    = !r_s2_valid || !s2_has_res || !r_out_valid || !i_out_stall;
    assign s2_fire    = r_s2_valid && s2_move;
    assign o_in_stall = !s2_move;

    // up, left, center, right, down; a pixel shifts the middle row first
    always_comb begin
        if (s2_px) begin
            taps[0] = r_win[0];
            taps[1] = r_win[2];
            taps[2] = r_win[3];
            taps[3] = mid_rd;
            taps[4] = r_win[4];
        end else begin
            taps = r_win;
        end
    end

    cmf_mean5 u_mean (
        .i_pix  (taps),
        .o_mean (mean)
    );

    assign interior = (r_out_row != '0) && (r_out_col != '0)
                   && (CMP_W'(r_out_row) + CMP_W'(2) <= CMP_W'(h_dim))
                   && (CMP_W'(r_out_col) + CMP_W'(2) <= CMP_W'(w_dim));

    always_comb begin
        n_win     = r_win;
        n_pend    = r_pend;
        n_primed  = r_primed;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        out_last  = 1'b0;
        if (s2_px) begin
            n_win[0] = up_rd;
            n_win[1] = r_win[2];
            n_win[2] = r_win[3];
            n_win[3] = mid_rd;
            n_win[4] = s2_pix;
            n_pend   = r_pend + cmf_pkg::PEND_W'(1) - cmf_pkg::PEND_W'(s2_has_res);
            n_primed = r_s2_last && (n_pend != '0);
        end else if (s2_has_res) begin
            n_pend = r_pend - cmf_pkg::PEND_W'(1);
            if (n_pend == '0) begin
                n_primed = 1'b0;
            end
        end
        if (s2_has_res) begin
            if (CMP_W'(r_out_col) + CMP_W'(1) >= CMP_W'(w_dim)) begin
                n_out_col = '0;
                if (CMP_W'(r_out_row) + CMP_W'(1) >= CMP_W'(h_dim)) begin
                    n_out_row = '0;
                    out_last  = 1'b1;
                end else begin
                    n_out_row = r_out_row + cmf_pkg::ROW_W'(1);
                end
            end else begin
                n_out_col = r_out_col + cmf_pkg::COL_W'(1);
            end
        end
    end

    assign res_item.red_out   = interior ? mean[2*cmf_pkg::CH_W +: cmf_pkg::CH_W] : '0;
    assign res_item.green_out = interior ? mean[cmf_pkg::CH_W +: cmf_pkg::CH_W] : '0;
    assign res_item.blue_out  = interior ? mean[0 +: cmf_pkg::CH_W] : '0;
    assign res_item.frame_end = out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cmf_pkg::TAPS; k++) begin
                r_win[k] <= '0;
            end
            r_pend    <= '0;
            r_primed  <= 1'b0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (s2_fire) begin
            r_win     <= n_win;
            r_pend    <= n_pend;
            r_primed  <= n_primed;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire && s2_has_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && s2_has_res) begin
            r_out_item <= res_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### sv/cmf_checker.sv
// port-level checks of the cross mean filter, bound to the top level
`default_nettype none

module cmf_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_in_valid,
    input wire                            o_in_stall,
    input wire                            o_out_valid,
    input wire                            i_out_stall,
    input cmf_pkg::t_out_item             o_out_item
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output transaction changed while stalled");

    // the input only backs up behind a full, stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // a fresh result follows an accepted input transaction
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result appeared without a triggering transaction");

    // the last pixel of a frame is a corner, hence border and zero
    a_frame_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.frame_end |->
            o_out_item.red_out == '0 && o_out_item.green_out == '0
            && o_out_item.blue_out == '0)
        else $error("frame end pixel is not zero");

endmodule

bind cross_mean_filter_top cmf_checker u_cmf_checker (.*);

`default_nettype wire
